// ----- hw/rtl/fbcb_pkg.sv -----
package fbcb_pkg;

  localparam int MAX_BLOCKS       = 2048;
  localparam int FIRST_DATA_BLOCK = 5;
  localparam int CARD_LIMIT       = 2048;
  localparam int MAP_AW           = $clog2(MAX_BLOCKS);

  localparam int BLK_W = 11;
  localparam int LEN_W = 12;
  localparam int CNT_W = 8;
  localparam int CFG_W = 12;
  localparam int STEP_W = 12;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_NEXT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_TOTAL_BLOCKS = 1'b0,
    REG_IGNORE_MAP   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_FALLBACK_RD,
    ST_FALLBACK_WR
  } state_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [BLK_W-1:0] block_index;
    logic [LEN_W-1:0] file_length;
    logic [CNT_W-1:0] map_value;
  } in_word_t;

  typedef struct packed {
    logic [BLK_W-1:0] chain_block;
    logic             last_of_chain;
    logic             fallback_phase;
  } out_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] card_size;
    logic             ignore_map;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    out_word_t         word;
  } emit_t;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic              re;
    logic [MAP_AW-1:0] raddr;
  } map_req_t;

  typedef struct packed {
    logic             wrap;
    logic [BLK_W-1:0] blk;
  } adv_t;

  // Card size in use: clipped to the map and to the block number range,
  // at least one data block past the system area.
  function automatic logic [LEN_W-1:0] card_size_of(input logic [CFG_W-1:0] total);
    logic [LEN_W:0] n;
    n = (LEN_W+1)'(total);
    if (n > (LEN_W+1)'(MAX_BLOCKS)) n = (LEN_W+1)'(MAX_BLOCKS);
    if (n > (LEN_W+1)'(CARD_LIMIT)) n = (LEN_W+1)'(CARD_LIMIT);
    if (n < (LEN_W+1)'(FIRST_DATA_BLOCK + 1)) n = (LEN_W+1)'(FIRST_DATA_BLOCK + 1);
    return LEN_W'(n);
  endfunction

  function automatic adv_t advance(input logic [BLK_W-1:0] p, input logic [LEN_W-1:0] cs);
    adv_t           a;
    logic [LEN_W:0] n;
    n = (LEN_W+1)'(p) + (LEN_W+1)'(1);
    if (n >= (LEN_W+1)'(cs)) begin
      a.wrap = 1'b1;
      a.blk  = BLK_W'(FIRST_DATA_BLOCK);
    end else begin
      a.wrap = 1'b0;
      a.blk  = BLK_W'(n);
    end
    return a;
  endfunction

endpackage

// ----- hw/rtl/fbcb_ram.sv -----
module fbcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/fbcb_ctrl.sv -----
module fbcb_ctrl
  import fbcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  input  cfg_t             cfg,
  input  logic             slot_free,
  output emit_t            emit,
  output map_req_t         map_req,
  input  logic [CNT_W-1:0] map_rdata
);

  state_t              state_r, state_nxt;
  logic [MAP_AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [BLK_W-1:0]    cursor_r, cursor_nxt;
  logic [BLK_W-1:0]    blocks_left_r, blocks_left_nxt;
  logic [BLK_W-1:0]    chain_start_r, chain_start_nxt;
  logic [BLK_W-1:0]    last_given_r, last_given_nxt;
  logic                has_wrapped_r, has_wrapped_nxt;
  logic                in_fallback_r, in_fallback_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;

  adv_t                adv_cur, adv_last, adv_idx;
  logic [STEP_W-1:0]   limit;
  logic [STEP_W-1:0]   steps_inc;
  logic [LEN_W-1:0]    len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      cursor_r      <= '0;
      blocks_left_r <= '0;
      chain_start_r <= '0;
      last_given_r  <= '0;
      has_wrapped_r <= 1'b0;
      in_fallback_r <= 1'b0;
      steps_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      cursor_r      <= cursor_nxt;
      blocks_left_r <= blocks_left_nxt;
      chain_start_r <= chain_start_nxt;
      last_given_r  <= last_given_nxt;
      has_wrapped_r <= has_wrapped_nxt;
      in_fallback_r <= in_fallback_nxt;
      steps_r       <= steps_nxt;
    end
  end

  always_comb begin
    adv_cur   = advance(cursor_r, cfg.card_size);
    adv_last  = advance(last_given_r, cfg.card_size);
    adv_idx   = advance(in_word.block_index, cfg.card_size);
    limit     = STEP_W'(cfg.card_size) + STEP_W'(2);
    steps_inc = steps_r + STEP_W'(1);
    len       = (in_word.file_length == '0) ? LEN_W'(1) : in_word.file_length;
    if (len > LEN_W'(CARD_LIMIT)) len = LEN_W'(CARD_LIMIT);

    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    cursor_nxt      = cursor_r;
    blocks_left_nxt = blocks_left_r;
    chain_start_nxt = chain_start_r;
    last_given_nxt  = last_given_r;
    has_wrapped_nxt = has_wrapped_r;
    in_fallback_nxt = in_fallback_r;
    steps_nxt       = steps_r;

    in_ready = 1'b0;
    emit     = '0;
    map_req  = '0;

    unique case (state_r)
      ST_CLEAR: begin
        map_req.we    = 1'b1;
        map_req.waddr = clr_addr_r;
        map_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + MAP_AW'(1);
        if (clr_addr_r == MAP_AW'(MAX_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          unique case (in_word.command)
            CMD_LOAD: begin
              if ((LEN_W+1)'(in_word.block_index) < (LEN_W+1)'(MAX_BLOCKS)) begin
                map_req.we    = 1'b1;
                map_req.waddr = MAP_AW'(in_word.block_index);
                map_req.wdata = cfg.ignore_map ? '0 : in_word.map_value;
              end
            end
            CMD_BEGIN: begin
              chain_start_nxt = in_word.block_index;
              last_given_nxt  = in_word.block_index;
              blocks_left_nxt = BLK_W'(len - LEN_W'(1));
              has_wrapped_nxt = adv_idx.wrap;
              in_fallback_nxt = 1'b0;
              cursor_nxt      = adv_idx.blk;
              emit.valid               = 1'b1;
              emit.word.chain_block    = in_word.block_index;
              emit.word.last_of_chain  = (len == LEN_W'(1));
              emit.word.fallback_phase = 1'b0;
            end
            CMD_NEXT: begin
              if (blocks_left_r != '0) begin
                if (in_fallback_r) begin
                  state_nxt = ST_FALLBACK_RD;
                end else if (cursor_r == chain_start_r) begin
                  in_fallback_nxt = 1'b1;
                  cursor_nxt      = adv_last.blk;
                  state_nxt       = ST_FALLBACK_RD;
                end else begin
                  map_req.re    = 1'b1;
                  map_req.raddr = MAP_AW'(cursor_r);
                  steps_nxt     = '0;
                  state_nxt     = ST_SEARCH;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Used entries are skipped one per cycle: check the entry read
      // last cycle and already issue the read of the following one.
      ST_SEARCH: begin
        if (map_rdata == '0) begin
          if (slot_free) begin
            if (!has_wrapped_r) begin
              map_req.we    = 1'b1;
              map_req.waddr = MAP_AW'(cursor_r);
              map_req.wdata = CNT_W'(1);
            end
            blocks_left_nxt          = blocks_left_r - BLK_W'(1);
            last_given_nxt           = cursor_r;
            cursor_nxt               = adv_cur.blk;
            has_wrapped_nxt          = has_wrapped_r | adv_cur.wrap;
            emit.valid               = 1'b1;
            emit.word.chain_block    = cursor_r;
            emit.word.last_of_chain  = (blocks_left_r == BLK_W'(1));
            emit.word.fallback_phase = 1'b0;
            state_nxt                = ST_IDLE;
          end
        end else begin
          has_wrapped_nxt = has_wrapped_r | adv_cur.wrap;
          steps_nxt       = steps_inc;
          if (steps_inc == limit || adv_cur.blk == chain_start_r) begin
            // back at the start block, or no free block on the card
            in_fallback_nxt = 1'b1;
            cursor_nxt      = adv_last.blk;
            state_nxt       = ST_FALLBACK_RD;
          end else begin
            cursor_nxt    = adv_cur.blk;
            map_req.re    = 1'b1;
            map_req.raddr = MAP_AW'(adv_cur.blk);
          end
        end
      end

      ST_FALLBACK_RD: begin
        map_req.re    = 1'b1;
        map_req.raddr = MAP_AW'(cursor_r);
        state_nxt     = ST_FALLBACK_WR;
      end

      ST_FALLBACK_WR: begin
        if (slot_free) begin
          map_req.we    = 1'b1;
          map_req.waddr = MAP_AW'(cursor_r);
          map_req.wdata = (map_rdata == '1) ? map_rdata : map_rdata + CNT_W'(1);
          blocks_left_nxt          = blocks_left_r - BLK_W'(1);
          last_given_nxt           = cursor_r;
          cursor_nxt               = adv_cur.blk;
          emit.valid               = 1'b1;
          emit.word.chain_block    = cursor_r;
          emit.word.last_of_chain  = (blocks_left_r == BLK_W'(1));
          emit.word.fallback_phase = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/free_block_chain_builder_core.sv -----
// Channel | Ports                          | Moves
// input   | in_valid, in_ready, in_word    | command word (load, begin, next)
// output  | out_valid, out_ready, out_word | chain block word
// config  | cfg_we, cfg_index, cfg_data    | register write, no wait
//
// Load and begin finish in the idle state. Next walks past each used block
// in the search state (the map memory is read once a cycle); a fallback
// block takes a read and a write state. One command is in work at a time.
// After reset the map is cleared one entry a cycle, all MAX_BLOCKS (2048)
// entries, and no word is accepted until it is done.
// A full output register holds the walk until the word is taken.
module free_block_chain_builder_core
  import fbcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] total_blocks_r;
  logic             ignore_map_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  cfg_t             cfg;
  emit_t            emit;
  map_req_t         map_req;
  logic [CNT_W-1:0] map_rdata;
  logic             slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= CFG_W'(CARD_LIMIT);
      ignore_map_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_BLOCKS: total_blocks_r <= cfg_data;
        REG_IGNORE_MAP:   ignore_map_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.card_size  = card_size_of(total_blocks_r);
  assign cfg.ignore_map = ignore_map_r;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_word_r <= emit.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  fbcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cfg       (cfg),
    .slot_free (slot_free),
    .emit      (emit),
    .map_req   (map_req),
    .map_rdata (map_rdata)
  );

  fbcb_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (map_req.we),
    .waddr (map_req.waddr),
    .wdata (map_req.wdata),
    .re    (map_req.re),
    .raddr (map_req.raddr),
    .rdata (map_rdata)
  );

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import fbcb_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  free_block_chain_builder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block's state
  logic [CNT_W-1:0] count_map [MAX_BLOCKS];
  logic [CFG_W-1:0] total_reg = CFG_W'(2048);
  logic             ignore_reg = 1'b0;
  int               walk_pos = 0;
  int               chain_head = 0;
  int               prev_given = 0;
  int               remaining = 0;
  bit               wrapped = 1'b0;
  bit               fallback_walk = 1'b0;

  in_word_t  command_q [$];
  out_word_t pending_blocks [$];

  int  words_pushed = 0;
  int  words_taken = 0;
  int  blocks_checked = 0;
  int  fallback_seen = 0;
  int  mismatches = 0;
  int  settings_run = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  in_took = 1'b0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;

  function automatic int card_blocks();
    int n;
    n = total_reg;
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    if (n > CARD_LIMIT) n = CARD_LIMIT;
    if (n < FIRST_DATA_BLOCK + 1) n = FIRST_DATA_BLOCK + 1;
    return n;
  endfunction

  // Past the card end the walk goes back to the first data block
  function automatic int step_pos(input int p, inout bit wrap_seen);
    int n;
    n = p + 1;
    if (n >= card_blocks()) begin
      n = FIRST_DATA_BLOCK;
      wrap_seen = 1'b1;
    end
    return n;
  endfunction

  task automatic apply_command(input in_word_t w);
    int        len;
    int        steps;
    int        blk;
    bit        found;
    bit        dummy;
    out_word_t o;
    found = 1'b0;
    dummy = 1'b0;
    case (w.command)
      CMD_LOAD: begin
        count_map[w.block_index] = ignore_reg ? '0 : w.map_value;
      end
      CMD_BEGIN: begin
        len = w.file_length;
        if (len == 0) len = 1;
        if (len > CARD_LIMIT) len = CARD_LIMIT;
        chain_head = w.block_index;
        prev_given = w.block_index;
        remaining = len - 1;
        wrapped = 1'b0;
        fallback_walk = 1'b0;
        walk_pos = step_pos(w.block_index, wrapped);
        o.chain_block = w.block_index;
        o.last_of_chain = (remaining == 0);
        o.fallback_phase = 1'b0;
        pending_blocks.push_back(o);
      end
      CMD_NEXT: begin
        if (remaining != 0) begin
          if (!fallback_walk) begin
            for (steps = 0; steps < card_blocks() + 2; steps++) begin
              if (walk_pos == chain_head) break;
              if (count_map[walk_pos] == '0) begin
                found = 1'b1;
                break;
              end
              walk_pos = step_pos(walk_pos, wrapped);
            end
            // met the start block or gave up: restart after the last block given
            if (!found) begin
              fallback_walk = 1'b1;
              walk_pos = step_pos(prev_given, dummy);
            end
          end
          blk = walk_pos;
          if (found) begin
            if (!wrapped) count_map[blk] = CNT_W'(1);
            walk_pos = step_pos(blk, wrapped);
          end else begin
            if (count_map[blk] != '1) count_map[blk] = count_map[blk] + 1'b1;
            walk_pos = step_pos(blk, dummy);
          end
          remaining = remaining - 1;
          prev_given = blk;
          o.chain_block = BLK_W'(blk);
          o.last_of_chain = (remaining == 0);
          o.fallback_phase = !found;
          pending_blocks.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_block(input out_word_t got);
    out_word_t want;
    if (pending_blocks.size() == 0) begin
      mismatches++;
      $display("%0t: expected no word, got blk=%0d last=%0d fb=%0d", $time,
               got.chain_block, got.last_of_chain, got.fallback_phase);
    end else begin
      want = pending_blocks.pop_front();
      blocks_checked++;
      if (want.fallback_phase) fallback_seen++;
      if (got.chain_block !== want.chain_block ||
          got.last_of_chain !== want.last_of_chain ||
          got.fallback_phase !== want.fallback_phase) begin
        mismatches++;
        $display("%0t: mismatch expected blk=%0d last=%0d fb=%0d, got blk=%0d last=%0d fb=%0d",
                 $time, want.chain_block, want.last_of_chain, want.fallback_phase,
                 got.chain_block, got.last_of_chain, got.fallback_phase);
      end
    end
  endtask

  // Results before commands: a word leaving at this edge belongs to an older command
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) check_block(out_word);
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        words_taken++;
        apply_command(in_word);
      end
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL_BLOCKS) total_reg = cfg_data;
        else ignore_reg = cfg_data[0];
      end
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= command_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_word(input cmd_t c, input int idx, input int len, input int val);
    in_word_t w;
    w.command = c;
    w.block_index = idx[BLK_W-1:0];
    w.file_length = len[LEN_W-1:0];
    w.map_value = val[CNT_W-1:0];
    command_q.push_back(w);
    words_pushed++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (words_taken != words_pushed || pending_blocks.size() != 0);
    // a next with no chain gives no word
    repeat (24) @(posedge clk);
  endtask

  // Mostly well-formed chains (begin plus its nexts), with loads and noise mixed in
  task automatic queue_mixed(input int count, input int span);
    int made;
    int r;
    int len;
    int nexts;
    int start;
    int val;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 6) begin
        push_word(cmd_t'($urandom_range(3)), $urandom_range(2047), $urandom_range(4095),
                  $urandom_range(255));
        made++;
      end else if (r < 30) begin
        case ($urandom_range(3))
          0, 1: val = 0;
          2: val = ($urandom_range(1) != 0) ? 255 : 1;
          default: val = $urandom_range(255);
        endcase
        start = ($urandom_range(99) < 85) ? $urandom_range(span - 1) : $urandom_range(2047);
        push_word(CMD_LOAD, start, $urandom_range(4095), val);
        made++;
      end else begin
        r = $urandom_range(99);
        if (r < 75) len = $urandom_range(10, 1);
        else if (r < 85) len = 0;
        else if (r < 92) len = $urandom_range(40, 11);
        else len = $urandom_range(4095, 41);
        start = ($urandom_range(99) < 85) ? $urandom_range(span - 1) : $urandom_range(2047);
        nexts = (len == 0) ? 0 : ((len > CARD_LIMIT) ? CARD_LIMIT - 1 : len - 1);
        if (nexts > 40) nexts = 40;
        r = $urandom_range(99);
        if (r < 10) nexts = nexts - $urandom_range(nexts);
        else if (r < 20) nexts = nexts + $urandom_range(2, 1);
        push_word(CMD_BEGIN, start, len, $urandom_range(255));
        repeat (nexts)
          push_word(CMD_NEXT, $urandom_range(2047), $urandom_range(4095), $urandom_range(255));
        made += 1 + nexts;
      end
    end
  endtask

  task automatic run_phase(input int total, input bit ignore, input int send_pct,
                           input int recv_pct, input int count, input bit hold);
    int span;
    write_reg(REG_TOTAL_BLOCKS, total);
    write_reg(REG_IGNORE_MAP, ignore);
    settings_run++;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    span = total;
    if (span > CARD_LIMIT) span = CARD_LIMIT;
    if (span < FIRST_DATA_BLOCK + 1) span = FIRST_DATA_BLOCK + 1;
    @(posedge clk);
    if (hold) hold_request = 1'b1;
    queue_mixed(count, span);
    wait_drained();
  endtask

  initial begin
    #60_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    foreach (count_map[i]) count_map[i] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // full-size card, reset settings
    push_word(CMD_LOAD, 2047, 0, 255);
    push_word(CMD_LOAD, 0, 0, 0);
    push_word(CMD_NOP, 2047, 4095, 255);
    push_word(CMD_NEXT, 0, 0, 0);         // no chain active
    push_word(CMD_BEGIN, 2047, 0, 0);     // zero length acts as one
    push_word(CMD_NEXT, 1, 1, 1);
    push_word(CMD_BEGIN, 2046, 4095, 0);  // length saturates
    push_word(CMD_NEXT, 0, 0, 0);         // skips the used last block and wraps
    push_word(CMD_NEXT, 0, 0, 0);
    push_word(CMD_BEGIN, 0, 1, 0);
    wait_drained();

    // smallest card: a single data block
    write_reg(REG_TOTAL_BLOCKS, 6);
    settings_run++;
    push_word(CMD_LOAD, 5, 0, 254);
    push_word(CMD_BEGIN, 5, 4, 0);        // walk meets the start at once
    repeat (3) push_word(CMD_NEXT, 0, 0, 0);
    push_word(CMD_LOAD, 5, 0, 0);
    push_word(CMD_BEGIN, 2, 5, 0);
    repeat (4) push_word(CMD_NEXT, 0, 0, 0);  // last one exhausts the walk
    push_word(CMD_BEGIN, 2000, 3, 0);     // start off the card
    repeat (2) push_word(CMD_NEXT, 0, 0, 0);
    wait_drained();

    run_phase(6, 1'b0, 0, 0, 150, 1'b1);
    run_phase(40, 1'b0, 72, 0, 300, 1'b0);
    run_phase(17, 1'b1, 0, 72, 250, 1'b0);
    run_phase(2048, 1'b0, 36, 36, 200, 1'b0);
    run_phase(4095, 1'b1, 0, 0, 150, 1'b0);
    run_phase(0, 1'b0, 72, 0, 150, 1'b0);
    run_phase(100, 1'b0, 36, 36, 300, 1'b0);

    $display("Ran %0d commands under %0d register settings, card sizes 6 to 2048.",
             words_taken, settings_run);
    $display("Checked %0d chain words, %0d of them from fallback walks.",
             blocks_checked, fallback_seen);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/fbcb_pkg.sv
hw/rtl/fbcb_ram.sv
hw/rtl/fbcb_ctrl.sv
hw/rtl/free_block_chain_builder_core.sv
tb/testbench.sv
